// ===== sv/spk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk_pkg
// shared constants and codes for the servo packet slave
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int FRAME_BYTES_DEF  = 8;
  localparam int EEPROM_WORDS_DEF = 24;
  localparam int TABLE_WORDS_DEF  = 53;
  localparam int ID_ADDR_DEF      = 3;
  localparam int LEVEL_ADDR_DEF   = 16;
  localparam int FLAG_ADDR_DEF    = 44;

  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = 6;
  localparam int REPLY_BYTES = 8;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] BCAST_ID = 8'hFE;
  localparam logic [7:0] ERR_INST = 8'h40;
  localparam logic [7:0] ERR_SUM  = 8'h10;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  typedef enum logic [7:0] {
    INS_PING   = 8'h01,
    INS_READ   = 8'h02,
    INS_WRITE  = 8'h03,
    INS_REG    = 8'h04,
    INS_ACTION = 8'h05,
    INS_RESET  = 8'h06,
    INS_SYNC   = 8'h83
  } ins_t;

endpackage

// ===== sv/spk_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spk channel interfaces
// valid/ready channels for received bytes and reply bytes
// ----------------------------------------------------------------------------
interface spk_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface spk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;
  modport source (output valid, output tx_byte, output last, input ready);
  modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

// ===== sv/servo_packet_slave.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_packet_slave
// slave side of a half-duplex servo bus: assembles frames, runs the
// instruction on a register store and streams the reply frame
// ----------------------------------------------------------------------------
// path: checksum item -> execute-stage registers -> reply queue -> reply bytes
// throughput: one item per cycle; the item that would finish a frame waits while
//   the previous frame is in the execute stage or its reply (6 to 8 bytes) drains
// reset: rst_n synchronous active low clears assembly, error, pending write,
//   reply queue and the store valid bits (store reads zero until written)
module servo_packet_slave #(
  parameter int FRAME_BYTES  = spk_pkg::FRAME_BYTES_DEF,
  parameter int EEPROM_WORDS = spk_pkg::EEPROM_WORDS_DEF,
  parameter int TABLE_WORDS  = spk_pkg::TABLE_WORDS_DEF,
  parameter int ID_ADDR      = spk_pkg::ID_ADDR_DEF,
  parameter int LEVEL_ADDR   = spk_pkg::LEVEL_ADDR_DEF,
  parameter int FLAG_ADDR    = spk_pkg::FLAG_ADDR_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  spk_in_if.sink           in_ch,
  spk_out_if.source        out_ch
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int AW = spk_pkg::STORE_AW;

  // ---------------- frame assembly ----------------
  logic [CW-1:0] cnt_r, cnt_nxt, idx;
  logic [7:0]    id_r, len_r, ins_r, p0_r, p1_r, sum_r;
  logic          in_acc, is_byte, cmpl, could_cmpl, busy;
  logic [7:0]    b;

  assign b       = in_ch.rx_byte;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign is_byte = (in_ch.func == spk_pkg::FUNC_BYTE);
  assign idx     = (cnt_r >= CW'(FRAME_BYTES)) ? '0 : cnt_r;

  // this item would close the frame (checksum position reached)
  assign could_cmpl = (idx > CW'(3)) &&
                      ((9'(idx) + 9'd1) == ({1'b0, len_r} + 9'd4));

  // only the frame-closing item has to wait for the reply path
  assign in_ch.ready = !(busy && could_cmpl);

  always_comb begin
    cnt_nxt = cnt_r;
    cmpl    = 1'b0;
    if (in_acc) begin
      if (!is_byte) begin
        cnt_nxt = '0;
      end else if ((idx == CW'(0) || idx == CW'(1)) && b != spk_pkg::HDR_BYTE) begin
        cnt_nxt = '0;
      end else if (idx == CW'(3) &&
                   (b < 8'd2 || ({1'b0, b} + 9'd4) > 9'(FRAME_BYTES))) begin
        cnt_nxt = '0;
      end else if (could_cmpl) begin
        cnt_nxt = '0;
        cmpl    = 1'b1;
      end else begin
        cnt_nxt = idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // header and first two parameters, plus running sum from the id on
  always_ff @(posedge clk) begin
    if (in_acc && is_byte) begin
      if (idx == CW'(2)) id_r  <= b;
      if (idx == CW'(3)) len_r <= b;
      if (idx == CW'(4)) ins_r <= b;
      if (idx == CW'(5)) p0_r  <= b;
      if (idx == CW'(6)) p1_r  <= b;
      if (idx == CW'(2)) begin
        sum_r <= b;
      end else if (idx > CW'(2)) begin
        sum_r <= sum_r + b;
      end
    end
  end

  // ---------------- execute stage ----------------
  logic       ex_v_r, ex_ok_r;
  logic [7:0] ex_id_r, ex_ins_r, ex_p0_r, ex_p1_r;
  logic [7:0] p0e;

  // a parameter past the received length reads as zero
  assign p0e = (len_r > 8'd2) ? p0_r : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r <= 1'b0;
    end else begin
      ex_v_r <= cmpl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmpl) begin
      ex_ok_r  <= (b == ~sum_r);
      ex_id_r  <= id_r;
      ex_ins_r <= ins_r;
      ex_p0_r  <= p0e;
      ex_p1_r  <= (len_r > 8'd3) ? p1_r : 8'd0;
    end
  end

  // register store: one write port, one registered read port
  logic [7:0]             mem [spk_pkg::STORE_DEPTH];
  logic [spk_pkg::STORE_DEPTH-1:0] vld_r;
  logic [7:0]             mem_q_r;
  logic                   mem_qv_r;
  logic                   we;
  logic [7:0]             wa, wd;
  logic                   wa_in;

  assign wa_in = ({1'b0, wa} < 9'(spk_pkg::STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmpl) begin
      mem_q_r  <= mem[p0e[AW-1:0]];
      mem_qv_r <= vld_r[p0e[AW-1:0]] && ({1'b0, p0e} < 9'(spk_pkg::STORE_DEPTH));
    end
    if (we && wa_in) begin
      mem[wa[AW-1:0]] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we && wa_in) begin
      vld_r[wa[AW-1:0]] <= 1'b1;
    end
  end

  // shadow copies of the fixed-address registers, plus error and pending write
  logic [7:0] myid_r, lvl_r, flg_r, err_r, pa_r, pd_r;
  logic [7:0] myid_nxt, lvl_nxt, flg_nxt, err_nxt, pa_nxt, pd_nxt;
  logic [7:0] rdv, lvl_aft, rerr, rp0, rp1;
  logic [1:0] n;
  logic       send, talk;
  logic       p0_ee, p0_tab, pa_tab;

  assign talk   = (ex_id_r != spk_pkg::BCAST_ID);
  assign p0_ee  = ({1'b0, ex_p0_r} < 9'(EEPROM_WORDS));
  assign p0_tab = ({1'b0, ex_p0_r} < 9'(TABLE_WORDS));
  assign pa_tab = ({1'b0, pa_r} < 9'(TABLE_WORDS));
  // flag lives in its shadow register, the memory copy is not used
  assign rdv = (ex_p0_r == 8'(FLAG_ADDR)) ? flg_r : (mem_qv_r ? mem_q_r : 8'd0);

  always_comb begin
    err_nxt = err_r;
    flg_nxt = flg_r;
    pa_nxt  = pa_r;
    pd_nxt  = pd_r;
    we      = 1'b0;
    wa      = ex_p0_r;
    wd      = ex_p1_r;
    send    = 1'b0;
    n       = 2'd0;
    rerr    = err_r;
    rp0     = 8'd0;
    rp1     = 8'd0;
    lvl_aft = lvl_r;
    if (ex_v_r) begin
      if (!ex_ok_r) begin
        // checksum mismatch
        if (talk && lvl_r != 8'd0) begin
          rerr    = err_r | spk_pkg::ERR_SUM;
          send    = 1'b1;
          err_nxt = 8'd0;
        end
      end else if (ex_id_r == myid_r || !talk) begin
        case (ex_ins_r)
          spk_pkg::INS_PING: begin
            if (talk && lvl_r != 8'd0) send = 1'b1;
            else err_nxt = 8'd0;
          end
          spk_pkg::INS_READ: begin
            if (talk && lvl_r != 8'd0) begin
              send = 1'b1;
              if (p0_ee) begin
                n   = 2'd1;
                rp0 = rdv;
              end else if (p0_tab) begin
                n   = 2'd2;
                rp0 = ex_p0_r;
                rp1 = rdv;
              end else begin
                rerr    = err_r | spk_pkg::ERR_INST;
                err_nxt = 8'd0;
              end
            end else begin
              err_nxt = 8'd0;
            end
          end
          spk_pkg::INS_WRITE: begin
            if (p0_tab) begin
              we = 1'b1;
              if (ex_p0_r == 8'(FLAG_ADDR)) flg_nxt = ex_p1_r;
            end else begin
              err_nxt = err_r | spk_pkg::ERR_INST;
            end
            lvl_aft = (we && wa == 8'(LEVEL_ADDR)) ? wd : lvl_r;
            if (talk && lvl_aft == 8'd2) begin
              send    = 1'b1;
              n       = 2'd2;
              rp0     = ex_p0_r;
              rp1     = ex_p1_r;
              rerr    = err_nxt;
              err_nxt = 8'd0;
            end
          end
          spk_pkg::INS_REG: begin
            pa_nxt  = ex_p0_r;
            pd_nxt  = ex_p1_r;
            flg_nxt = 8'd1;
          end
          spk_pkg::INS_ACTION: begin
            if (flg_r == 8'd1) begin
              flg_nxt = 8'd0;
              if (pa_tab) begin
                we = 1'b1;
                wa = pa_r;
                wd = pd_r;
                if (pa_r == 8'(FLAG_ADDR)) flg_nxt = pd_r;
              end else begin
                err_nxt = err_r | spk_pkg::ERR_INST;
              end
            end else begin
              err_nxt = err_r | spk_pkg::ERR_INST;
            end
            lvl_aft = (we && wa == 8'(LEVEL_ADDR)) ? wd : lvl_r;
            if (talk && lvl_aft == 8'd2) begin
              send = 1'b1;
              rerr = err_nxt;
            end
            err_nxt = 8'd0;
          end
          spk_pkg::INS_RESET: begin
            if (talk && lvl_r == 8'd2) send = 1'b1;
            err_nxt = 8'd0;
          end
          spk_pkg::INS_SYNC: begin
            if (flg_r != 8'd0) flg_nxt = 8'd0;
            else err_nxt = err_r | spk_pkg::ERR_INST;
            if (talk && lvl_r == 8'd2) begin
              send = 1'b1;
              rerr = err_nxt;
            end
            err_nxt = 8'd0;
          end
          default: begin
            // unknown instruction
            if (talk && lvl_r == 8'd2) begin
              send = 1'b1;
              rerr = err_r | spk_pkg::ERR_INST;
            end
            err_nxt = 8'd0;
          end
        endcase
      end
    end
    myid_nxt = (we && wa == 8'(ID_ADDR)) ? wd : myid_r;
    lvl_nxt  = (we && wa == 8'(LEVEL_ADDR)) ? wd : lvl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      myid_r <= 8'd0;
      lvl_r  <= 8'd0;
      flg_r  <= 8'd0;
      err_r  <= 8'd0;
      pa_r   <= 8'd0;
      pd_r   <= 8'd0;
    end else begin
      myid_r <= myid_nxt;
      lvl_r  <= lvl_nxt;
      flg_r  <= flg_nxt;
      err_r  <= err_nxt;
      pa_r   <= pa_nxt;
      pd_r   <= pd_nxt;
    end
  end

  // ---------------- reply queue ----------------
  logic [7:0] rb_r [spk_pkg::REPLY_BYTES];
  logic [7:0] rb_nxt [spk_pkg::REPLY_BYTES];
  logic [3:0] rem_r, rem_nxt;
  logic [7:0] cks, rlen;
  logic       out_acc;

  assign busy    = ex_v_r || (rem_r != 4'd0);
  assign out_acc = out_ch.valid && out_ch.ready;
  assign rlen    = {6'd0, n} + 8'd2;
  assign cks     = ~(ex_id_r + rlen + rerr + rp0 + rp1);

  assign out_ch.valid   = (rem_r != 4'd0);
  assign out_ch.tx_byte = rb_r[0];
  assign out_ch.last    = (rem_r == 4'd1);

  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < spk_pkg::REPLY_BYTES; i++) rb_nxt[i] = rb_r[i];
    if (send) begin
      // queue is empty here: frame completion waited for it
      rb_nxt[0] = spk_pkg::HDR_BYTE;
      rb_nxt[1] = spk_pkg::HDR_BYTE;
      rb_nxt[2] = ex_id_r;
      rb_nxt[3] = rlen;
      rb_nxt[4] = rerr;
      rb_nxt[5] = (n == 2'd0) ? cks : rp0;
      rb_nxt[6] = (n == 2'd1) ? cks : rp1;
      rb_nxt[7] = cks;
      rem_nxt   = 4'd6 + {2'd0, n};
    end else if (out_acc) begin
      for (int i = 0; i < spk_pkg::REPLY_BYTES - 1; i++) rb_nxt[i] = rb_r[i+1];
      rem_nxt = rem_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 4'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < spk_pkg::REPLY_BYTES; i++) rb_r[i] <= rb_nxt[i];
  end

endmodule
